// File: src/sha1_pkg.sv
// Shared types, constants and round functions for the SHA-1 hash engine.
package sha1_pkg;

  localparam int ROUNDS      = 80;
  localparam int BLOCK_BYTES = 64;
  localparam int CHAIN_WORDS = 5;
  localparam int POS_W       = $clog2(BLOCK_BYTES);
  localparam int RND_W       = $clog2(ROUNDS);
  localparam int WIDX_W      = 3;

  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(BLOCK_BYTES - 1);
  localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(56);

  localparam logic [31:0] SHA1_IV [CHAIN_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD80,
    S_ZERO,
    S_LEN,
    S_ROUND,
    S_FIN,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    BSEL_IN,
    BSEL_80,
    BSEL_ZERO,
    BSEL_LEN
  } bsel_t;

  typedef enum logic [1:0] {
    RS_CH,
    RS_PAR1,
    RS_MAJ,
    RS_PAR2
  } rstage_t;

  typedef struct packed {
    logic              load_en;
    bsel_t             byte_sel;
    logic              count_byte;
    logic              round_en;
    rstage_t           round_sel;
    logic              chain_add;
    logic              restart;
    logic [WIDX_W-1:0] word_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_last;
    logic pos_length;
  } dp_stat_t;

  function automatic logic [31:0] round_k(input rstage_t s);
    logic [31:0] k;
    unique case (s)
      RS_CH:   k = 32'h5A827999;
      RS_PAR1: k = 32'h6ED9EBA1;
      RS_MAJ:  k = 32'h8F1BBCDC;
      RS_PAR2: k = 32'hCA62C1D6;
      default: k = 32'h5A827999;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] round_f(input rstage_t s, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (s)
      RS_CH:   f = (b & c) | (~b & d);
      RS_MAJ:  f = (b & c) | (b & d) | (c & d);
      RS_PAR1,
      RS_PAR2: f = b ^ c ^ d;
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

// File: src/sha1_dp.sv
// Datapath of the SHA-1 engine: block shift register, round unit, chaining words.
module sha1_dp import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  in_byte,
  output dp_stat_t    stat,
  output logic [31:0] digest_word
);

  // The block is a 512-bit shift line; the oldest word sits at the top.
  logic [511:0] blk_r, blk_nxt;
  logic [31:0]  a_r, b_r, c_r, d_r, e_r;
  logic [31:0]  a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [31:0]  chain_r [CHAIN_WORDS];
  logic [31:0]  chain_nxt [CHAIN_WORDS];
  logic [63:0]  bitlen_r, bitlen_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;

  logic [7:0]  byte_val;
  logic [31:0] w0, w2, w8, w13, w_mix, w_new, tmp;
  logic        blk_full;

  assign w0    = blk_r[511:480];
  assign w2    = blk_r[447:416];
  assign w8    = blk_r[255:224];
  assign w13   = blk_r[95:64];
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_mix[30:0], w_mix[31]};

  assign tmp = {a_r[26:0], a_r[31:27]} + round_f(cmd.round_sel, b_r, c_r, d_r)
             + e_r + round_k(cmd.round_sel) + w0;

  assign blk_full = cmd.load_en && (pos_r == POS_LAST);

  always_comb begin
    unique case (cmd.byte_sel)
      BSEL_IN:   byte_val = in_byte;
      BSEL_80:   byte_val = 8'h80;
      BSEL_ZERO: byte_val = 8'h00;
      BSEL_LEN:  byte_val = bitlen_r[63:56];
      default:   byte_val = 8'h00;
    endcase
  end

  always_comb begin
    blk_nxt    = blk_r;
    pos_nxt    = pos_r;
    bitlen_nxt = bitlen_r;
    a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r; e_nxt = e_r;
    for (int i = 0; i < CHAIN_WORDS; i++) chain_nxt[i] = chain_r[i];

    if (cmd.load_en) begin
      blk_nxt = {blk_r[503:0], byte_val};
      pos_nxt = pos_r + POS_W'(1);
      if (cmd.byte_sel == BSEL_LEN) bitlen_nxt = {bitlen_r[55:0], bitlen_r[63:56]};
    end
    if (cmd.count_byte) bitlen_nxt = bitlen_r + 64'd8;

    if (blk_full) begin
      a_nxt = chain_r[0]; b_nxt = chain_r[1]; c_nxt = chain_r[2];
      d_nxt = chain_r[3]; e_nxt = chain_r[4];
    end else if (cmd.round_en) begin
      blk_nxt = {blk_r[479:0], w_new};
      e_nxt = d_r;
      d_nxt = c_r;
      c_nxt = {b_r[1:0], b_r[31:2]};
      b_nxt = a_r;
      a_nxt = tmp;
    end

    if (cmd.chain_add) begin
      chain_nxt[0] = chain_r[0] + a_r;
      chain_nxt[1] = chain_r[1] + b_r;
      chain_nxt[2] = chain_r[2] + c_r;
      chain_nxt[3] = chain_r[3] + d_r;
      chain_nxt[4] = chain_r[4] + e_r;
    end
    if (cmd.restart) begin
      for (int i = 0; i < CHAIN_WORDS; i++) chain_nxt[i] = SHA1_IV[i];
      bitlen_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHAIN_WORDS; i++) chain_r[i] <= SHA1_IV[i];
      bitlen_r <= '0;
      pos_r    <= '0;
    end else begin
      for (int i = 0; i < CHAIN_WORDS; i++) chain_r[i] <= chain_nxt[i];
      bitlen_r <= bitlen_nxt;
      pos_r    <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
    a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt; e_r <= e_nxt;
  end

  always_comb begin
    unique case (cmd.word_sel)
      3'd0:    digest_word = chain_r[0];
      3'd1:    digest_word = chain_r[1];
      3'd2:    digest_word = chain_r[2];
      3'd3:    digest_word = chain_r[3];
      3'd4:    digest_word = chain_r[4];
      default: digest_word = chain_r[0];
    endcase
  end

  assign stat.pos_last   = (pos_r == POS_LAST);
  assign stat.pos_length = (pos_r == POS_LENGTH);

endmodule

// File: src/sha1_ctrl.sv
// Controller of the SHA-1 engine: sequences byte intake, padding, rounds and digest output.
module sha1_ctrl import sha1_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_has_byte,
  input  logic              in_eom,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic              out_last,
  output logic [WIDX_W-1:0] out_index,
  input  dp_stat_t          stat,
  output dp_cmd_t           cmd
);

  state_t state_r, state_nxt;
  state_t resume_r, resume_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic [2:0]        lenc_r, lenc_nxt;
  logic [WIDX_W-1:0] widx_r, widx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      resume_r <= S_IDLE;
      rnd_r    <= '0;
      lenc_r   <= '0;
      widx_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      resume_r <= resume_nxt;
      rnd_r    <= rnd_nxt;
      lenc_r   <= lenc_nxt;
      widx_r   <= widx_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    resume_nxt = resume_r;
    rnd_nxt    = '0;
    lenc_nxt   = lenc_r;
    widx_nxt   = widx_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd          = '0;
    cmd.byte_sel = BSEL_IN;
    cmd.word_sel = widx_r;

    if (rnd_r < RND_W'(20))      cmd.round_sel = RS_CH;
    else if (rnd_r < RND_W'(40)) cmd.round_sel = RS_PAR1;
    else if (rnd_r < RND_W'(60)) cmd.round_sel = RS_MAJ;
    else                         cmd.round_sel = RS_PAR2;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_en    = in_has_byte;
          cmd.count_byte = in_has_byte;
          if (in_has_byte && stat.pos_last) begin
            state_nxt  = S_ROUND;
            resume_nxt = in_eom ? S_PAD80 : S_IDLE;
          end else if (in_eom) begin
            state_nxt = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.load_en  = 1'b1;
        cmd.byte_sel = BSEL_80;
        if (stat.pos_last) begin
          state_nxt  = S_ROUND;
          resume_nxt = S_ZERO;
        end else begin
          state_nxt = S_ZERO;
        end
      end
      S_ZERO: begin
        lenc_nxt = '0;
        if (stat.pos_length) begin
          state_nxt = S_LEN;
        end else begin
          cmd.load_en  = 1'b1;
          cmd.byte_sel = BSEL_ZERO;
          if (stat.pos_last) begin
            state_nxt  = S_ROUND;
            resume_nxt = S_ZERO;
          end
        end
      end
      S_LEN: begin
        cmd.load_en  = 1'b1;
        cmd.byte_sel = BSEL_LEN;
        lenc_nxt     = lenc_r + 3'd1;
        if (lenc_r == 3'd7) begin
          state_nxt  = S_ROUND;
          resume_nxt = S_OUT;
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        rnd_nxt      = rnd_r + RND_W'(1);
        if (rnd_r == RND_W'(ROUNDS - 1)) begin
          rnd_nxt   = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.chain_add = 1'b1;
        widx_nxt      = '0;
        state_nxt     = resume_r;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (widx_r == WIDX_W'(CHAIN_WORDS - 1)) begin
            cmd.restart = 1'b1;
            widx_nxt    = '0;
            state_nxt   = S_IDLE;
          end else begin
            widx_nxt = widx_r + WIDX_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_last  = (widx_r == WIDX_W'(CHAIN_WORDS - 1));
  assign out_index = widx_r;

  // Input intake and digest output never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output channels active together");

  // The round counter never runs past the last round.
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> (rnd_r <= RND_W'(ROUNDS - 1)))
    else $error("round counter out of range");

  // The final digest word returns the engine to idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_last) |=> (state_r == S_IDLE))
    else $error("engine did not return to idle after digest");

  // Every block compression ends with a chain update.
  a_fin_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && rnd_r == RND_W'(ROUNDS - 1)) |=> (state_r == S_FIN))
    else $error("compression not followed by chain update");

endmodule

// File: src/sha1_hash_engine.sv
// Top level of the SHA-1 hash engine: byte stream in, five digest words out.
// Throughput: one input transaction per cycle until a byte fills the 64-byte block, then
// the block's SHA-1 rounds and a chain update follow before input is taken again.
// From the end-of-message transaction to the first digest word, the padding bytes are
// loaded and one or two compressions run.
// Synchronous active-low reset loads the initial vector and clears length and position.
module sha1_hash_engine import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // end_of_message
  // Digest channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);

  // The controller decides each cycle what the datapath does; the datapath
  // reports only whether the block is full and whether padding reached the
  // length field. The controller accepts no input transaction while a block
  // compresses, while padding runs, or while the digest is being delivered.
  // The five digest words leave one per accepted output transaction.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha1_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_has_byte (in_tuser),
    .in_eom      (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_last    (out_tlast),
    .out_index   (out_tuser),
    .stat        (stat),
    .cmd         (cmd)
  );

  // The digest word is read straight from the chaining registers, which stay
  // stable for the whole output phase.
  sha1_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_byte     (in_tdata),
    .stat        (stat),
    .digest_word (out_tdata)
  );

endmodule

// File: dv/sha1_digest_checker.sv
// Checker that predicts SHA-1 digests from input transactions and compares the digest channel.
`timescale 1ns / 1ps
module sha1_digest_checker import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          mismatches,
  output int          words_outstanding
);

  localparam logic [31:0] K_CHOOSE   = 32'h5A827999;
  localparam logic [31:0] K_PARITY_A = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
  localparam logic [31:0] K_PARITY_B = 32'hCA62C1D6;
  localparam logic [5:0]  LEN_FIELD_POS = 6'd56;
  localparam logic [7:0]  PAD_MARKER    = 8'h80;

  typedef struct packed {
    logic [31:0]       word;
    logic [WIDX_W-1:0] index;
    logic              last;
  } digest_word_t;

  logic [31:0]  chain [CHAIN_WORDS];
  logic [31:0]  blk [16];
  logic [63:0]  bit_count;
  logic [5:0]   fill_pos;
  digest_word_t digest_q [$];

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 80; i++) w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = K_CHOOSE;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = K_PARITY_A;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJORITY;
      end else begin
        f = b ^ c ^ d;
        k = K_PARITY_B;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endfunction

  // Bytes land big-endian within each 32-bit word.
  function automatic void absorb_byte(input logic [7:0] v);
    int sh;
    sh = (3 - int'(fill_pos[1:0])) * 8;
    if (fill_pos[1:0] == 2'd0) blk[fill_pos[5:2]] = '0;
    blk[fill_pos[5:2]][sh +: 8] = v;
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) compress_block();
  endfunction

  function automatic void restart_digest();
    for (int i = 0; i < CHAIN_WORDS; i++) chain[i] = SHA1_IV[i];
    bit_count = '0;
    fill_pos  = '0;
  endfunction

  function automatic void finish_message();
    logic [63:0] len;
    len = bit_count;
    absorb_byte(PAD_MARKER);
    while (fill_pos != LEN_FIELD_POS) absorb_byte(8'h00);
    for (int i = 7; i >= 0; i--) absorb_byte(len[i*8 +: 8]);
    for (int i = 0; i < CHAIN_WORDS; i++) begin
      digest_q.push_back('{word: chain[i], index: WIDX_W'(i), last: (i == CHAIN_WORDS - 1)});
    end
    restart_digest();
  endfunction

  always @(posedge clk) begin : monitor
    digest_word_t exp_w;
    if (!rst_n) begin
      restart_digest();
      digest_q.delete();
    end else begin
      // Results are checked first; a digest never leaves in the cycle its message ends.
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          mismatches++;
          $error("digest word %h (index %0d) arrived with nothing expected", out_tdata, out_tuser);
        end else begin
          exp_w = digest_q.pop_front();
          if (out_tdata !== exp_w.word) begin
            mismatches++;
            $error("digest_word: expected %h, actual %h", exp_w.word, out_tdata);
          end
          if (out_tuser !== exp_w.index) begin
            mismatches++;
            $error("word_index: expected %0d, actual %0d", exp_w.index, out_tuser);
          end
          if (out_tlast !== exp_w.last) begin
            mismatches++;
            $error("last_word: expected %0b, actual %0b", exp_w.last, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser) begin
          absorb_byte(in_tdata);
          bit_count += 64'd8;
        end
        if (in_tlast) finish_message();
      end
    end
    words_outstanding = digest_q.size();
  end

endmodule

// File: dv/sha1_hash_engine_tb.sv
// Top of the SHA-1 hash engine testbench: clock, reset, byte-stream stimulus and the verdict.
`timescale 1ns / 1ps
module sha1_hash_engine_tb;

  // Roughly how many byte-carrying or message-ending transactions the random part sends.
  localparam int RANDOM_ITEMS = 470;
  // Cycles allowed to pass once the last digest word is out, well beyond one
  // full padding pass plus two compressions.
  localparam int DRAIN_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int mismatches;
  int words_outstanding;
  int items_sent = 0;
  // While set, neither side inserts idle cycles.
  logic no_gaps = 1'b0;

  sha1_hash_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sha1_digest_checker digest_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_tvalid         (in_tvalid),
    .in_tready         (in_tready),
    .in_tdata          (in_tdata),
    .in_tuser          (in_tuser),
    .in_tlast          (in_tlast),
    .out_tvalid        (out_tvalid),
    .out_tready        (out_tready),
    .out_tdata         (out_tdata),
    .out_tuser         (out_tuser),
    .out_tlast         (out_tlast),
    .mismatches        (mismatches),
    .words_outstanding (words_outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The digest side stalls with a chance of about one in ten, except during the steady stretch.
  always @(negedge clk) begin
    out_tready <= no_gaps || ($urandom_range(0, 99) >= 10);
  end

  // Drives one input transaction. Called at a falling edge; returns at the falling
  // edge after the transaction was accepted. An optional idle gap goes first, so
  // gaps land on every phase of the engine's work, including mid-compression.
  task automatic send_item(input logic [7:0] data, input logic has, input logic fin);
    int gap;
    gap = (!no_gaps && $urandom_range(0, 99) < 10) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= has;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (has || fin) items_sent++;
    @(negedge clk);
  endtask

  // A transaction with neither a byte nor an end: the engine must ignore it.
  // The data bits are random since they carry no meaning here.
  task automatic send_noise();
    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  // Sends a message of len random bytes. The end either rides with the last byte
  // or follows as a separate empty tail. Ignored transactions are sprinkled in.
  task automatic send_message(input int len);
    logic tail_with_byte;
    tail_with_byte = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 4) send_noise();
      send_item(8'($urandom_range(0, 255)), 1'b1, tail_with_byte && (i == len - 1));
    end
    if (!tail_with_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Lengths around the padding boundaries: the length field just fits (55),
  // forces a second block (56, 57), and whole blocks with neighbors.
  int boundary_lens [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  initial begin : stimulus
    int roll;
    int len;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Empty message: an end with no byte ever given.
    send_item(8'hC3, 1'b0, 1'b1);
    // Ignored transactions between messages.
    send_noise();
    send_noise();
    // Single byte, all zeros, carried together with the end.
    send_item(8'h00, 1'b1, 1'b1);
    // The classic three-byte message "abc".
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // All-ones byte, then a byte that looks like the pad marker, then an empty tail.
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // An ignored transaction in the middle of a message must not disturb it.
    send_item(8'h5A, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hA5, 1'b1, 1'b1);

    // Random part: whole messages with random content. Half are short so that
    // many digests come out; some sit on padding and block boundaries, a few are long.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      no_gaps <= (items_sent >= 150) && (items_sent < 300);
      roll = $urandom_range(0, 99);
      if (roll < 50) len = $urandom_range(0, 12);
      else if (roll < 80) len = boundary_lens[$urandom_range(0, 9)];
      else len = $urandom_range(13, 140);
      send_message(len);
    end
    in_tvalid <= 1'b0;

    // Wait for every predicted digest word, then watch for stray results.
    while (words_outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run.
  initial begin : watchdog
    #1000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: files.f
src/sha1_pkg.sv
src/sha1_dp.sv
src/sha1_ctrl.sv
src/sha1_hash_engine.sv
dv/sha1_digest_checker.sv
dv/sha1_hash_engine_tb.sv
